// ===== hw/rtl/utf8vc_pkg.sv =====
`default_nettype none

package utf8vc_pkg;

   // Counter width used when the top level is not told otherwise.
   localparam int CNT_BITS_DEFAULT = 32;

   // Width of every count and offset field as it leaves the block.
   localparam int FIELD_W = 32;

   // Result data: string_valid, char_count, end_offset, padded to whole bytes.
   localparam int RSP_DATA_W = 72;

   // Register indexes on the configuration channel.
   localparam logic CSR_LIMIT_ENABLE = 1'b0;
   localparam logic CSR_BYTE_LIMIT   = 1'b1;

   typedef struct packed {
      logic       first_byte;
      logic [7:0] data_byte;
   } in_item_type;

   typedef struct packed {
      logic               limit_enable;
      logic [FIELD_W-1:0] byte_limit;
   } cfg_type;

   typedef struct packed {
      logic               string_valid;
      logic [FIELD_W-1:0] char_count;
      logic [FIELD_W-1:0] end_offset;
      logic               limit_hit;
   } result_type;

   // Character length announced by a lead byte.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b < 8'hC0) begin
         len = 3'd1;
      end else if (b < 8'hE0) begin
         len = 3'd2;
      end else if (b < 8'hF0) begin
         len = 3'd3;
      end else if (b < 8'hF8) begin
         len = 3'd4;
      end else if (b < 8'hFC) begin
         len = 3'd5;
      end else if (b < 8'hFE) begin
         len = 3'd6;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b >= 8'h80) && (b <= 8'hBF);
   endfunction

   // Checks a character of one to four bytes; bytes past its length are ignored.
   function automatic logic char_valid(input logic [2:0] len, input logic [7:0] ld,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic [7:0] b4);
      logic ok;
      ok = 1'b1;
      if (ld > 8'hF4) ok = 1'b0;
      if ((ld >= 8'h80) && (ld < 8'hC2)) ok = 1'b0;
      if ((len >= 3'd2) && !is_cont(b2)) ok = 1'b0;
      if ((len >= 3'd3) && !is_cont(b3)) ok = 1'b0;
      if (len == 3'd4) begin
         if (!is_cont(b4)) ok = 1'b0;
         // Plane-final noncharacters nFFFE and nFFFF.
         if (((b4 == 8'hBE) || (b4 == 8'hBF)) && (b3 == 8'hBF) && (b2[3:0] == 4'hF)) ok = 1'b0;
      end
      if (len >= 3'd2) begin
         if ((ld == 8'hE0) && (b2 < 8'hA0)) ok = 1'b0;
         if ((ld == 8'hED) && (b2 > 8'h9F)) ok = 1'b0;
         if ((ld == 8'hEF) && (len == 3'd3)) begin
            if ((b2 == 8'hB7) && (b3 >= 8'h90) && (b3 <= 8'hAF)) ok = 1'b0;
            if ((b2 == 8'hBF) && ((b3 == 8'hBE) || (b3 == 8'hBF))) ok = 1'b0;
         end
         if ((ld == 8'hF0) && (b2 < 8'h90)) ok = 1'b0;
         if ((ld == 8'hF4) && (b2 > 8'h8F)) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8vc_in_stage.sv =====
`default_nettype none

module utf8vc_in_stage
   import utf8vc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        advance,
   output      logic        item_valid,
   output      in_item_type item
);

   logic        valid_ff;
   logic        valid_in;
   in_item_type item_ff;
   logic        accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.first_byte <= req_tuser;
         item_ff.data_byte  <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8vc_scan.sv =====
`default_nettype none

module utf8vc_scan
   import utf8vc_pkg::*;
#(
   parameter int COUNTER_BITS = CNT_BITS_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire in_item_type item,
   input  wire cfg_type     cfg,
   output      logic        res_valid,
   output      result_type  res
);

   localparam int CW = (COUNTER_BITS >= FIELD_W) ? FIELD_W : COUNTER_BITS;
   localparam logic [CW-1:0] CMAX = '1;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == CMAX) ? v : v + CW'(1);
   endfunction

   logic [2:0]    pending_ff, pending_in, c_pending;
   logic [2:0]    len_ff, len_in, c_len;
   logic [7:0]    lead_ff, lead_in, c_lead;
   logic [7:0]    b2_ff, b2_in, c_b2;
   logic [7:0]    b3_ff, b3_in, c_b3;
   logic          char_ok_ff, char_ok_in, c_char_ok;
   logic          all_ok_ff, all_ok_in, c_all_ok;
   logic          stopped_ff, stopped_in, c_stopped;
   logic [CW-1:0] offset_ff, offset_in, c_offset;
   logic [CW-1:0] start_ff, start_in, c_start;
   logic [CW-1:0] count_ff, count_in, c_count;
   logic [CW-1:0] bad_ff, bad_in, c_bad;

   logic [7:0]    b;
   logic [2:0]    pos;
   logic [2:0]    new_len;
   logic [7:0]    nb2, nb3;
   logic          done_ok;
   logic          fin;
   logic [CW-1:0] fin_start;
   logic          over_limit;
   logic [FIELD_W-1:0] report_offset;

   always_comb begin
      // A first byte starts from the cleared string state.
      if (item.first_byte) begin
         c_pending = '0;
         c_len     = '0;
         c_lead    = '0;
         c_b2      = '0;
         c_b3      = '0;
         c_char_ok = 1'b1;
         c_all_ok  = 1'b1;
         c_stopped = 1'b0;
         c_offset  = '0;
         c_start   = '0;
         c_count   = '0;
         c_bad     = '0;
      end else begin
         c_pending = pending_ff;
         c_len     = len_ff;
         c_lead    = lead_ff;
         c_b2      = b2_ff;
         c_b3      = b3_ff;
         c_char_ok = char_ok_ff;
         c_all_ok  = all_ok_ff;
         c_stopped = stopped_ff;
         c_offset  = offset_ff;
         c_start   = start_ff;
         c_count   = count_ff;
         c_bad     = bad_ff;
      end
   end

   assign b             = item.data_byte;
   assign pos           = c_len - c_pending;
   assign nb2           = (pos == 3'd1) ? b : c_b2;
   assign nb3           = (pos == 3'd2) ? b : c_b3;
   assign new_len       = lead_len(b);
   assign over_limit    = ({1'b0, FIELD_W'(c_offset)} + (FIELD_W + 1)'(new_len))
                          >= {1'b0, cfg.byte_limit};
   assign report_offset = FIELD_W'(c_all_ok ? c_offset : c_bad);

   always_comb begin
      pending_in = c_pending;
      len_in     = c_len;
      lead_in    = c_lead;
      b2_in      = c_b2;
      b3_in      = c_b3;
      char_ok_in = c_char_ok;
      stopped_in = c_stopped;
      offset_in  = c_offset;
      start_in   = c_start;
      res_valid  = 1'b0;
      res        = '0;
      fin        = 1'b0;
      done_ok    = 1'b1;
      fin_start  = c_start;

      if (!c_stopped) begin
         if (c_pending != 3'd0) begin
            // Continuation byte of the current character.
            b2_in      = nb2;
            b3_in      = nb3;
            pending_in = c_pending - 3'd1;
            offset_in  = sat_inc(c_offset);
            if (c_pending == 3'd1) begin
               fin     = 1'b1;
               done_ok = c_char_ok && (c_len <= 3'd4) && char_valid(c_len, c_lead, nb2, nb3, b);
            end
         end else if (cfg.limit_enable &&
                      ((cfg.byte_limit == '0) || ((b != 8'h00) && over_limit))) begin
            // The next character would not fit inside the byte limit.
            res_valid        = step;
            res.string_valid = 1'b0;
            res.char_count   = FIELD_W'(c_count);
            res.end_offset   = report_offset;
            res.limit_hit    = 1'b1;
            stopped_in       = 1'b1;
         end else if (b == 8'h00) begin
            // Terminator in lead position.
            res_valid        = step;
            res.string_valid = c_all_ok;
            res.char_count   = FIELD_W'(c_count);
            res.end_offset   = report_offset;
            res.limit_hit    = 1'b0;
            stopped_in       = 1'b1;
         end else begin
            start_in   = c_offset;
            fin_start  = c_offset;
            lead_in    = b;
            len_in     = new_len;
            char_ok_in = (new_len <= 3'd4);
            offset_in  = sat_inc(c_offset);
            if (new_len == 3'd1) begin
               fin     = 1'b1;
               done_ok = char_valid(3'd1, b, 8'h00, 8'h00, 8'h00);
            end else begin
               pending_in = new_len - 3'd1;
            end
         end
      end
   end

   // Closing a character bumps the count and records the first bad start.
   always_comb begin
      count_in  = c_count;
      all_ok_in = c_all_ok;
      bad_in    = c_bad;
      if (fin) begin
         count_in = sat_inc(c_count);
         if (!done_ok && c_all_ok) begin
            bad_in    = fin_start;
            all_ok_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         len_ff     <= '0;
         lead_ff    <= '0;
         b2_ff      <= '0;
         b3_ff      <= '0;
         char_ok_ff <= 1'b1;
         all_ok_ff  <= 1'b1;
         stopped_ff <= 1'b0;
         offset_ff  <= '0;
         start_ff   <= '0;
         count_ff   <= '0;
         bad_ff     <= '0;
      end else if (step) begin
         pending_ff <= pending_in;
         len_ff     <= len_in;
         lead_ff    <= lead_in;
         b2_ff      <= b2_in;
         b3_ff      <= b3_in;
         char_ok_ff <= char_ok_in;
         all_ok_ff  <= all_ok_in;
         stopped_ff <= stopped_in;
         offset_ff  <= offset_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         bad_ff     <= bad_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8vc_out_stage.sv =====
`default_nettype none

module utf8vc_out_stage
   import utf8vc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire result_type            res,
   output      logic                  free,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tuser
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // The register can take a new result when empty or when it drains now.
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({res_ff.end_offset, res_ff.char_count, res_ff.string_valid});
   assign rsp_tuser  = res_ff.limit_hit;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_validate_and_count_top.sv =====
// UTF-8 string validator and character counter.
//
// Bytes of a string arrive on the req_ channel, one per transaction, with
// req_tuser set on the first byte of a new string. The block checks every
// character, counts characters and tracks the start of the first bad one.
// A zero byte in lead position ends the string; when the byte limit is
// enabled, a character that would not fit ends it early. Each end gives one
// transaction on the rsp_ channel; all other bytes give none.
// The csr_ channel writes limit_enable (index 0) and byte_limit (index 1);
// it is always ready and should only be used while the block is idle.
// A terminating byte is held in the input register, scanned combinationally,
// and its result is captured in the result register that drives rsp_tvalid.
// Throughput is one byte per cycle while the result register is free (empty or
// draining); the string state is updated between the input and result registers.
// Reset clears both registers, the string state and the configuration.
// When the receiver stalls, the result holds in its register; the input
// register takes one more byte and then req_tready stays low until the
// receiver takes the waiting result.
`default_nettype none

module utf8_validate_and_count_top
   import utf8vc_pkg::*;
#(
   parameter int COUNTER_BITS = CNT_BITS_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Byte input.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // data_byte
   input  wire logic                  req_tuser,   // first_byte
   // Result output.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // string_valid, char_count, end_offset
   output      logic                  rsp_tuser,   // limit_hit
   // Configuration writes.
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [FIELD_W-1:0]    csr_wdata
);

   in_item_type item;
   logic        item_valid;
   logic        advance;
   logic        out_free;
   logic        res_valid;
   result_type  res;
   cfg_type     cfg_ff;
   cfg_type     cfg_in;

   // A held byte moves on whenever the result register can take what it makes.
   assign advance = item_valid && out_free;

   // Configuration registers; writes are never refused.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LIMIT_ENABLE: cfg_in.limit_enable = csr_wdata[0];
            CSR_BYTE_LIMIT:   cfg_in.byte_limit   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   utf8vc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   utf8vc_scan #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   utf8vc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/utf8vc_checker.sv =====
`default_nettype none

module utf8vc_checker
   import utf8vc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A string stopped by the limit is never reported valid.
   a_limit_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("limit stop reported as valid string");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A fresh result comes from a byte taken earlier on the input channel.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching input transaction");

endmodule

bind utf8_validate_and_count_top utf8vc_checker u_checker (.*);

`default_nettype wire

// ===== test/utf8_validate_and_count_top_tb.sv =====
`timescale 1ns / 100ps

module utf8_validate_and_count_top_tb;
   import utf8vc_pkg::*;

   typedef logic [7:0] octet_type;
   typedef enum bit {ROW_BYTE, ROW_CSR} row_kind_type;

   // One line of the directed plan. For a byte row, flag is first_byte and value holds
   // the byte; for a register row, flag is the register index and value the write data.
   typedef struct {
      row_kind_type kind;
      logic         flag;
      logic [31:0]  value;
      bit           typed;
      result_type   want;
   } plan_row_type;

   localparam result_type NO_RESULT = '0;
   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 6;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // data_byte
   logic                  req_tuser = 1'b0; // first_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // string_valid, char_count, end_offset
   logic                  rsp_tuser;        // limit_hit
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_LIMIT_ENABLE;
   logic [FIELD_W-1:0]    csr_wdata = '0;

   utf8_validate_and_count_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // String reports that the byte stream has produced but the block has not yet delivered.
   result_type due_reports[$];
   int         mismatches = 0;
   int         bytes_sent = 0;
   int         stuck_cycles = 0;

   // Idling control. While calm is set neither side inserts random gaps. A single
   // request on hold_ask makes the receiver back off while hold_left counts down.
   bit calm = 1'b0;
   bit hold_ask = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   // Shadow of the configuration registers.
   bit          lim_on = 1'b0;
   logic [31:0] lim_bytes = '0;

   // Shadow of the string scanner, at its reset values.
   logic [2:0]  pend = '0;
   logic [2:0]  clen = '0;
   octet_type   lead = '0;
   octet_type   b2nd = '0;
   octet_type   b3rd = '0;
   bit          cur_ok = 1'b1;
   bit          str_ok = 1'b1;
   bit          done = 1'b0;
   logic [31:0] offs = '0;
   logic [31:0] cstart = '0;
   logic [31:0] nchars = '0;
   logic [31:0] bad_at = '0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   // Length in bytes that a lead byte announces.
   function automatic logic [2:0] span_of(input octet_type b);
      if (!b[7] || b[7:6] == 2'b10) return 3'd1;
      if (b[7:5] == 3'b110) return 3'd2;
      if (b[7:4] == 4'b1110) return 3'd3;
      if (b[7:3] == 5'b11110) return 3'd4;
      if (b[7:2] == 6'b111110) return 3'd5;
      if (b[7:1] == 7'b1111110) return 3'd6;
      return 3'd1;
   endfunction

   // Legality of a one- to four-byte character; bytes beyond n are don't-care.
   function automatic bit seq_legal(input logic [2:0] n, input octet_type b0,
                                    input octet_type b1, input octet_type b2,
                                    input octet_type b3);
      if (b0 > 8'hF4 || (b0 >= 8'h80 && b0 <= 8'hC1)) return 1'b0;
      if (n >= 3'd2 && b1[7:6] != 2'b10) return 1'b0;
      if (n >= 3'd3 && b2[7:6] != 2'b10) return 1'b0;
      if (n == 3'd4) begin
         if (b3[7:6] != 2'b10) return 1'b0;
         // Last two code points of every supplementary plane.
         if (b3[7:1] == 7'h5F && b2 == 8'hBF && b1[3:0] == 4'hF) return 1'b0;
      end
      if (n >= 3'd2) begin
         case (b0)
            8'hE0: if (b1 < 8'hA0) return 1'b0;
            8'hED: if (b1 > 8'h9F) return 1'b0;
            8'hEF: begin
               if (n == 3'd3 && b1 == 8'hB7 && b2 >= 8'h90 && b2 <= 8'hAF) return 1'b0;
               if (n == 3'd3 && b1 == 8'hBF && b2[7:1] == 7'h5F) return 1'b0;
            end
            8'hF0: if (b1 < 8'h90) return 1'b0;
            8'hF4: if (b1 > 8'h8F) return 1'b0;
            default: ;
         endcase
      end
      return 1'b1;
   endfunction

   task automatic close_char(input bit ok);
      nchars = bump(nchars);
      if (!ok && str_ok) begin
         bad_at = cstart;
         str_ok = 1'b0;
      end
   endtask

   // Advances the shadow scanner by one byte. emits tells whether the byte ends the
   // string with a report.
   task automatic scan_byte(input logic first, input octet_type b, output bit emits,
                            output result_type rep);
      logic [2:0] n;
      logic [2:0] pos;
      emits = 1'b0;
      rep = NO_RESULT;
      if (first) begin
         pend = '0;
         clen = '0;
         lead = '0;
         b2nd = '0;
         b3rd = '0;
         cur_ok = 1'b1;
         str_ok = 1'b1;
         done = 1'b0;
         offs = '0;
         cstart = '0;
         nchars = '0;
         bad_at = '0;
      end
      if (done) return;
      if (pend != 3'd0) begin
         pos = clen - pend;
         if (pos == 3'd1) b2nd = b;
         else if (pos == 3'd2) b3rd = b;
         pend = pend - 3'd1;
         offs = bump(offs);
         if (pend == 3'd0) close_char(cur_ok && clen <= 3'd4 && seq_legal(clen, lead, b2nd, b3rd, b));
         return;
      end
      n = span_of(b);
      if (lim_on && (lim_bytes == '0 ||
          (b != 8'h00 && 64'(offs) + 64'(n) >= 64'(lim_bytes)))) begin
         rep.string_valid = 1'b0;
         rep.char_count = nchars;
         rep.end_offset = str_ok ? offs : bad_at;
         rep.limit_hit = 1'b1;
         done = 1'b1;
         emits = 1'b1;
         return;
      end
      if (b == 8'h00) begin
         rep.string_valid = str_ok;
         rep.char_count = nchars;
         rep.end_offset = str_ok ? offs : bad_at;
         rep.limit_hit = 1'b0;
         done = 1'b1;
         emits = 1'b1;
         return;
      end
      cstart = offs;
      lead = b;
      clen = n;
      cur_ok = (n <= 3'd4);
      offs = bump(offs);
      if (n == 3'd1) close_char(seq_legal(3'd1, b, 8'h00, 8'h00, 8'h00));
      else pend = n - 3'd1;
   endtask

   // Offers one byte, waits for the transaction, and records the report it causes.
   // A typed expectation replaces the predicted one for rows whose answer is obvious.
   task automatic push_byte(input logic first, input octet_type b, input bit typed,
                            input result_type want);
      bit         emits;
      result_type rep;
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      scan_byte(first, b, emits, rep);
      if (emits) due_reports.push_back(typed ? want : rep);
      bytes_sent++;
   endtask

   // Stops sending and waits until every report is back and the pipeline has settled.
   // Bytes that end no string leave no trace in the queue, so an extra settling wait follows.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_LIMIT_ENABLE) lim_on = v[0];
      else lim_bytes = v;
   endtask

   function automatic octet_type cont_byte();
      return octet_type'($urandom_range(8'hBF, 8'h80));
   endfunction

   // Appends one character. Most are well formed; the rest hit each class of fault
   // near its boundaries, or are plain noise.
   task automatic add_char(ref octet_type s[$]);
      int pick;
      int k;
      pick = $urandom_range(99);
      if (pick < 40) begin
         s.push_back(octet_type'($urandom_range(8'h7F, 8'h01)));
      end else if (pick < 55) begin
         s.push_back(octet_type'($urandom_range(8'hDF, 8'hC2)));
         s.push_back(cont_byte());
      end else if (pick < 68) begin
         s.push_back(octet_type'($urandom_range(8'hEF, 8'hE0)));
         s.push_back(cont_byte());
         s.push_back(cont_byte());
      end else if (pick < 78) begin
         s.push_back(octet_type'($urandom_range(8'hF4, 8'hF0)));
         repeat (3) s.push_back(cont_byte());
      end else if (pick < 92) begin
         case ($urandom_range(12))
            0: begin  // overlong three-byte form
               s.push_back(8'hE0);
               s.push_back(octet_type'($urandom_range(8'hA0, 8'h80)));
               s.push_back(cont_byte());
            end
            1: begin  // surrogate halves
               s.push_back(8'hED);
               s.push_back(octet_type'($urandom_range(8'hBF, 8'h9F)));
               s.push_back(cont_byte());
            end
            2: begin  // around the FDD0..FDEF block
               s.push_back(8'hEF);
               s.push_back(octet_type'($urandom_range(8'hB8, 8'hB6)));
               s.push_back(octet_type'($urandom_range(8'hB0, 8'h8F)));
            end
            3: begin  // around FFFE and FFFF
               s.push_back(8'hEF);
               s.push_back(octet_type'($urandom_range(8'hBF, 8'hBE)));
               s.push_back(octet_type'($urandom_range(8'hBF, 8'hBD)));
            end
            4: begin  // overlong four-byte form
               s.push_back(8'hF0);
               s.push_back(octet_type'($urandom_range(8'h90, 8'h80)));
               s.push_back(cont_byte());
               s.push_back(cont_byte());
            end
            5: begin  // edge of the code space
               s.push_back(8'hF4);
               s.push_back(octet_type'($urandom_range(8'h90, 8'h8F)));
               s.push_back(cont_byte());
               s.push_back(cont_byte());
            end
            6: begin  // plane-final noncharacters and their neighbors
               s.push_back(octet_type'($urandom_range(8'hF4, 8'hF0)));
               s.push_back({2'b10, 2'($urandom_range(3)), 4'($urandom_range(15, 14))});
               s.push_back(octet_type'($urandom_range(8'hBF, 8'hBE)));
               s.push_back(octet_type'($urandom_range(8'hBF, 8'hBD)));
            end
            7: begin  // overlong two-byte form
               s.push_back(octet_type'($urandom_range(8'hC1, 8'hC0)));
               s.push_back(cont_byte());
            end
            8: s.push_back(cont_byte());  // stray continuation
            9: s.push_back(octet_type'($urandom_range(8'hFF, 8'hF5)));
            10: begin  // five-byte form
               s.push_back(octet_type'($urandom_range(8'hFB, 8'hF8)));
               repeat (4) s.push_back(octet_type'($urandom_range(255)));
            end
            11: begin  // six-byte form
               s.push_back(octet_type'($urandom_range(8'hFD, 8'hFC)));
               repeat (5) s.push_back(octet_type'($urandom_range(255)));
            end
            default: begin  // broken continuation, zero included
               s.push_back(octet_type'($urandom_range(8'hDF, 8'hC2)));
               k = $urandom_range(255);
               if (k >= 8'h80 && k <= 8'hBF) k = k - 8'h80;
               s.push_back(octet_type'(k));
            end
         endcase
      end else begin
         s.push_back(octet_type'($urandom_range(255)));
      end
   endtask

   // One string: a few characters, usually a terminator, sometimes stray bytes after
   // it, and sometimes no end at all so that the next string cuts it off.
   task automatic send_string();
      octet_type s[$];
      int        ending;
      repeat ($urandom_range(10)) add_char(s);
      ending = $urandom_range(99);
      if (ending < 92) s.push_back(8'h00);
      if (ending >= 85 && ending < 92) begin
         repeat ($urandom_range(3, 1)) s.push_back(octet_type'($urandom_range(255)));
      end
      if (s.size() == 0) s.push_back(octet_type'($urandom_range(255)));
      foreach (s[i]) push_byte(i == 0, s[i], 1'b0, NO_RESULT);
   endtask

   // A random phase: settle, program the registers, then stream strings.
   task automatic run_phase(input bit le, input logic [31:0] lim, input int n_bytes,
                            input bit quiet, input bit squeeze);
      int stop_at;
      drain();
      write_reg(CSR_LIMIT_ENABLE, {31'b0, le});
      write_reg(CSR_BYTE_LIMIT, lim);
      calm <= quiet;
      if (squeeze) hold_ask <= 1'b1;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_string();
   endtask

   // Directed opening: bytes before any string start, the terminator, bytes after the
   // end, bad leads, a zero continuation, a string cut off mid-character, a five-byte
   // form, noncharacters, then the zero limit and an early limit stop.
   plan_row_type plan [28] = '{
      '{ROW_BYTE, 1'b0, 32'h41, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h00, 1'b1, '{1'b1, 32'd1, 32'd1, 1'b0}},
      '{ROW_BYTE, 1'b0, 32'h41, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b1, 32'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hC0, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h00, 1'b1, '{1'b0, 32'd2, 32'd0, 1'b0}},
      '{ROW_BYTE, 1'b1, 32'hE0, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h80, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b1, 32'hF8, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hEF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hF4, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h8F, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hBF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'h00, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_LIMIT_ENABLE, 32'd1, 1'b0, NO_RESULT},
      '{ROW_CSR,  CSR_BYTE_LIMIT, 32'd0, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b1, 32'h00, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b1}},
      '{ROW_CSR,  CSR_BYTE_LIMIT, 32'd3, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b1, 32'h41, 1'b0, NO_RESULT},
      '{ROW_BYTE, 1'b0, 32'hC3, 1'b1, '{1'b0, 32'd1, 32'd1, 1'b1}}
   };

   // Stimulus. The phases sweep the limit from off through the all-ones extreme, small
   // random limits, zero and one, and finally a random value with the limit disabled.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_reg(plan[i].flag, plan[i].value);
         end else begin
            push_byte(plan[i].flag, plan[i].value[7:0], plan[i].typed, plan[i].want);
         end
      end
      run_phase(1'b0, 32'hFFFF_FFFF, 380, 1'b0, 1'b0);
      run_phase(1'b1, 32'hFFFF_FFFF, 180, 1'b0, 1'b0);
      run_phase(1'b1, 32'($urandom_range(40, 1)), 280, 1'b1, 1'b0);
      // Every lead byte ends its string here, so a receiver that backs off fills the
      // block quickly and the input side must stall.
      run_phase(1'b1, 32'd0, 60, 1'b0, 1'b1);
      run_phase(1'b1, 32'd1, 60, 1'b0, 1'b0);
      run_phase(1'b1, 32'($urandom_range(40, 1)), 140, 1'b0, 1'b0);
      run_phase(1'b0, 32'($urandom), 380, 1'b0, 1'b0);
      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: checks every delivered report against the oldest one due, then picks
   // the ready level for the next cycle. A hold-off is counted down here.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.string_valid = rsp_tdata[0];
         got.char_count = rsp_tdata[32:1];
         got.end_offset = rsp_tdata[64:33];
         got.limit_hit = rsp_tuser;
         if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected report valid=%0d count=%0d offset=%0d limit=%0d",
                        $realtime, got.string_valid, got.char_count, got.end_offset,
                        got.limit_hit);
            end
         end else begin
            want = due_reports.pop_front();
            if (got.string_valid !== want.string_valid || got.char_count !== want.char_count
                || got.end_offset !== want.end_offset || got.limit_hit !== want.limit_hit) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("%0t: report mismatch, expected valid=%0d count=%0d offset=%0d",
                         $realtime, want.string_valid, want.char_count, want.end_offset);
                  $display(" limit=%0d, got valid=%0d count=%0d offset=%0d limit=%0d",
                           want.limit_hit, got.string_valid, got.char_count,
                           got.end_offset, got.limit_hit);
               end
            end
         end
      end
      if (hold_ask && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 27);
      end
   end

   // Watchdog: a run in which no transaction completes for too long has hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

// ===== files.f =====
hw/rtl/utf8vc_pkg.sv
hw/rtl/utf8vc_in_stage.sv
hw/rtl/utf8vc_scan.sv
hw/rtl/utf8vc_out_stage.sv
hw/rtl/utf8_validate_and_count_top.sv
hw/rtl/utf8vc_checker.sv
test/utf8_validate_and_count_top_tb.sv
